// File: hw/rtl/idafs_pkg.sv
package idafs_pkg;

	localparam int ID_W    = 10;
	localparam int OP_W    = 2;
	localparam int ST_W    = 2;
	localparam int EPOCH_W = 8;

	localparam logic [OP_W-1:0] OP_ALLOC       = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE     = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE_ALL = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_FREED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic [ID_W-1:0] release_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic [ST_W-1:0] status;
	} rsp_t;

	// One entry of the free-mark table: the mark counts only if its epoch is current.
	typedef struct packed {
		logic               set;
		logic [EPOCH_W-1:0] epoch;
	} mark_t;

	typedef struct packed {
		logic wr_en;
		logic wr_set;
		logic bump_epoch;
	} mark_cmd_t;

	typedef struct packed {
		logic is_set;
		logic sweep_busy;
	} mark_stat_t;

endpackage

// File: hw/rtl/idafs_free_stack.sv
module idafs_free_stack #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [IDX_W-1:0] push_id,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] top_id
);

	logic [IDX_W-1:0] mem [DEPTH];
	logic [IDX_W-1:0] rdata_q;
	logic             fwd_vld_q;
	logic [IDX_W-1:0] fwd_id_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_addr] <= push_id;
		end
		rdata_q  <= mem[rd_addr];
		fwd_id_q <= push_id;
	end

	// A push to the address being read in the same cycle wins over the old contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= push && (wr_addr == rd_addr);
		end
	end

	assign top_id = fwd_vld_q ? fwd_id_q : rdata_q;

endmodule

// File: hw/rtl/idafs_mark_table.sv
module idafs_mark_table #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      rd_addr,
	input  logic [IDX_W-1:0]      wr_addr,
	input  idafs_pkg::mark_cmd_t  cmd,
	output idafs_pkg::mark_stat_t stat
);

	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(DEPTH - 1);
	localparam int               EW        = idafs_pkg::EPOCH_W;

	idafs_pkg::mark_t mem [DEPTH];
	idafs_pkg::mark_t rdata_q;
	idafs_pkg::mark_t wdata;
	logic [IDX_W-1:0] waddr;
	logic             we;
	logic [EW-1:0]    epoch_q;
	logic             sweep_q;
	logic [IDX_W-1:0] sweep_addr_q;
	logic             fwd_vld_q;
	logic             fwd_set_q;
	logic             epoch_wrap;

	assign epoch_wrap = cmd.bump_epoch && (epoch_q == '1);

	always_comb begin
		if (sweep_q) begin
			we    = 1'b1;
			waddr = sweep_addr_q;
			wdata = '0;
		end else begin
			we          = cmd.wr_en;
			waddr       = wr_addr;
			wdata.set   = cmd.wr_set;
			wdata.epoch = epoch_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q   <= mem[rd_addr];
		fwd_set_q <= wdata.set;
	end

	// Release-all bumps the epoch; the table is swept after reset and on an epoch wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= '0;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			fwd_vld_q    <= 1'b0;
		end else begin
			fwd_vld_q <= we && !sweep_q && (waddr == rd_addr);
			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + IDX_W'(1);
				if (sweep_addr_q == LAST_ADDR) begin
					sweep_q <= 1'b0;
				end
			end else if (epoch_wrap) begin
				epoch_q      <= '0;
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end else if (cmd.bump_epoch) begin
				epoch_q <= epoch_q + EW'(1);
			end
		end
	end

	assign stat.is_set     = fwd_vld_q ? fwd_set_q
	                                   : (rdata_q.set && (rdata_q.epoch == epoch_q));
	assign stat.sweep_busy = sweep_q || epoch_wrap;

endmodule

// File: hw/rtl/id_allocator_free_stack_top.sv
// Slot-id allocator with a LIFO free stack and a high-water mark. A word is taken at a
// rising edge where start is high and busy is low, one word per cycle at most; the word is
// held in s1_q and its result is registered on rsp with done high for exactly one cycle;
// the receiver cannot stall, so every result must be captured when done is
// high. Busy is high after reset while the free-mark table is swept, and again starting
// in the cycle after every 256th release-all is taken, when the table's epoch counter
// wraps and stale marks must be wiped, until that sweep ends. At all other times busy
// stays low.
module id_allocator_free_stack_top #(
	parameter int MAX_IDS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  idafs_pkg::req_t req,
	output logic            done,
	output idafs_pkg::rsp_t rsp
);

	localparam int IDX_W  = (MAX_IDS > 2) ? $clog2(MAX_IDS) : 1;
	localparam int CNT_W  = $clog2(MAX_IDS + 1);
	localparam int IDW    = idafs_pkg::ID_W;
	localparam int WIDE_W = (CNT_W > IDW) ? CNT_W : IDW;
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_IDS);

	logic                  accept;
	logic                  s1_vld_q;
	idafs_pkg::req_t       s1_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic [CNT_W-1:0]      count_m1;
	logic [CNT_W-1:0]      used_q;
	logic [CNT_W-1:0]      used_d;
	logic [WIDE_W-1:0]     rid_wide;
	logic [WIDE_W-1:0]     used_wide;
	logic [IDX_W-1:0]      rid_idx;
	logic [IDX_W-1:0]      port_idx;
	logic [WIDE_W-1:0]     port_wide;
	logic [IDX_W-1:0]      top_id;
	logic                  push;
	logic [IDX_W-1:0]      mark_wr_addr;
	idafs_pkg::mark_cmd_t  mark_cmd;
	idafs_pkg::mark_stat_t mark_stat;
	idafs_pkg::rsp_t       rsp_d;
	logic                  sweep_busy;

	assign sweep_busy = mark_stat.sweep_busy;
	assign busy       = sweep_busy;
	assign accept     = start && !busy;

	assign port_wide = WIDE_W'(req.release_id);
	assign port_idx  = port_wide[IDX_W-1:0];
	assign rid_wide  = WIDE_W'(s1_q.release_id);
	assign rid_idx   = rid_wide[IDX_W-1:0];
	assign used_wide = WIDE_W'(used_q);

	always_comb begin
		count_d      = count_q;
		used_d       = used_q;
		push         = 1'b0;
		mark_cmd     = '0;
		mark_wr_addr = rid_idx;
		rsp_d        = '0;
		if (s1_vld_q) begin
			unique case (s1_q.opcode)
				idafs_pkg::OP_ALLOC: begin
					if (count_q != '0) begin
						// Pop the most recently freed id and drop its free mark.
						count_d          = count_q - CNT_W'(1);
						rsp_d.granted_id = IDW'(top_id);
						mark_cmd.wr_en   = 1'b1;
						mark_wr_addr     = top_id;
					end else if (used_q != MAX_C) begin
						rsp_d.granted_id = IDW'(used_q);
						used_d           = used_q + CNT_W'(1);
					end else begin
						rsp_d.status = idafs_pkg::ST_FULL;
					end
				end
				idafs_pkg::OP_RELEASE: begin
					if (rid_wide >= used_wide) begin
						rsp_d.status = idafs_pkg::ST_RANGE;
					end else if (rid_wide == used_wide - WIDE_W'(1)) begin
						used_d = used_q - CNT_W'(1);
					end else if (mark_stat.is_set) begin
						rsp_d.status = idafs_pkg::ST_FREED;
					end else if (count_q != MAX_C) begin
						push            = 1'b1;
						count_d         = count_q + CNT_W'(1);
						mark_cmd.wr_en  = 1'b1;
						mark_cmd.wr_set = 1'b1;
					end
				end
				idafs_pkg::OP_RELEASE_ALL: begin
					count_d             = '0;
					used_d              = '0;
					mark_cmd.bump_epoch = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// The stack top is fetched every cycle for the count the next word will see.
	assign count_m1 = count_d - CNT_W'(1);

	idafs_free_stack #(
		.DEPTH (MAX_IDS),
		.IDX_W (IDX_W)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_addr (count_q[IDX_W-1:0]),
		.push_id (rid_idx),
		.rd_addr (count_m1[IDX_W-1:0]),
		.top_id  (top_id)
	);

	idafs_mark_table #(
		.DEPTH (MAX_IDS),
		.IDX_W (IDX_W)
	) u_marks (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (port_idx),
		.wr_addr (mark_wr_addr),
		.cmd     (mark_cmd),
		.stat    (mark_stat)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= req;
		end
		rsp <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			done     <= 1'b0;
			count_q  <= '0;
			used_q   <= '0;
		end else begin
			s1_vld_q <= accept;
			done     <= s1_vld_q;
			count_q  <= count_d;
			used_q   <= used_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 2))
		else $error("result strobe does not follow an accepted word by two cycles");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= MAX_C) && (used_q <= MAX_C))
		else $error("free count or high-water mark exceeds the id space");

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_busy |=> !s1_vld_q)
		else $error("word accepted while the mark table was being swept");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != idafs_pkg::ST_OK)) |-> (rsp.granted_id == '0))
		else $error("failed operation returned a nonzero id");
`endif

endmodule

// File: sim/tb_id_allocator_free_stack_top.sv
module tb_id_allocator_free_stack_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_IDS    = 1024;
	localparam int STALL_MAX  = 8192;
	localparam int MODEL_GEN  = 0;
	localparam int MODEL_CHK  = 1;
	localparam int ID_W       = idafs_pkg::ID_W;
	localparam logic [idafs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	idafs_pkg::req_t req = '0;
	idafs_pkg::rsp_t rsp;

	// Words waiting to be sent, and results expected back, oldest first.
	idafs_pkg::req_t word_q[$];
	idafs_pkg::rsp_t grant_q[$];
	idafs_pkg::rsp_t oldest;

	int idle_pct = 16;
	int err_cnt = 0;
	int stall_cnt = 0;

	// Two copies of the allocator state: one steers the generator, one checks the block.
	logic [ID_W-1:0] free_ids [2][MAX_IDS];
	int              free_cnt [2];
	int              high_mark [2];
	bit              is_free [2][MAX_IDS];

	id_allocator_free_stack_top #(
		.MAX_IDS(MAX_IDS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_ids(input int m);
		free_cnt[m] = 0;
		high_mark[m] = 0;
		for (int i = 0; i < MAX_IDS; i++)
			is_free[m][i] = 1'b0;
	endfunction

	function automatic idafs_pkg::rsp_t predict_grant(input int m, input idafs_pkg::req_t w);
		idafs_pkg::rsp_t o;
		int rid;
		o = '0;
		o.status = idafs_pkg::ST_OK;
		rid = int'(w.release_id);
		case (w.opcode)
			idafs_pkg::OP_ALLOC: begin
				if (free_cnt[m] > 0) begin
					free_cnt[m]--;
					o.granted_id = free_ids[m][free_cnt[m]];
					is_free[m][o.granted_id] = 1'b0;
				end else if (high_mark[m] < MAX_IDS) begin
					o.granted_id = high_mark[m][ID_W-1:0];
					high_mark[m]++;
				end else begin
					o.status = idafs_pkg::ST_FULL;
				end
			end
			idafs_pkg::OP_RELEASE: begin
				if (rid >= high_mark[m]) begin
					o.status = idafs_pkg::ST_RANGE;
				end else if (rid + 1 == high_mark[m]) begin
					// The topmost id only pulls the mark down, even if it is on the stack.
					high_mark[m]--;
				end else if (is_free[m][rid]) begin
					o.status = idafs_pkg::ST_FREED;
				end else if (free_cnt[m] < MAX_IDS) begin
					free_ids[m][free_cnt[m]] = w.release_id;
					free_cnt[m]++;
					is_free[m][rid] = 1'b1;
				end
			end
			idafs_pkg::OP_RELEASE_ALL: begin
				clear_ids(m);
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		err_cnt++;
	endtask

	task automatic add_word(input logic [idafs_pkg::OP_W-1:0] op, input logic [ID_W-1:0] id);
		idafs_pkg::req_t w;
		idafs_pkg::rsp_t unused;
		w.opcode = op;
		w.release_id = id;
		word_q.insert(word_q.size(), w);
		unused = predict_grant(MODEL_GEN, w);
	endtask

	// Mostly allocates and legal releases, with repeats, topmost releases and some noise.
	task automatic random_burst(input int n);
		int pick;
		int hi;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			hi = high_mark[MODEL_GEN];
			if (pick < 45) begin
				add_word(idafs_pkg::OP_ALLOC, ID_W'($urandom));
			end else if (pick < 85 && hi > 0) begin
				if (pick < 55)
					add_word(idafs_pkg::OP_RELEASE, ID_W'(hi - 1));
				else if (pick < 62 && free_cnt[MODEL_GEN] > 0)
					add_word(idafs_pkg::OP_RELEASE,
						free_ids[MODEL_GEN][$urandom_range(free_cnt[MODEL_GEN] - 1)]);
				else
					add_word(idafs_pkg::OP_RELEASE, ID_W'($urandom_range(hi - 1)));
			end else if (pick < 93) begin
				add_word(idafs_pkg::OP_RELEASE, ID_W'($urandom));
			end else if (pick < 96) begin
				add_word(idafs_pkg::OP_RELEASE_ALL, ID_W'($urandom));
			end else begin
				add_word(OP_UNUSED, ID_W'($urandom));
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (word_q.size() != 0 || start || grant_q.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				req <= word_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (grant_q.size() == 0) begin
					report_mismatch($sformatf("result id=%0d status=%0d with no word pending",
						rsp.granted_id, rsp.status));
				end else begin
					oldest = grant_q.pop_front();
					if (rsp.granted_id !== oldest.granted_id)
						report_mismatch($sformatf("granted_id %0d, expected %0d",
							rsp.granted_id, oldest.granted_id));
					if (rsp.status !== oldest.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, oldest.status));
				end
			end
			if (start && !busy)
				grant_q.insert(grant_q.size(), predict_grant(MODEL_CHK, req));
		end
	end

	// The sweep after reset and after an epoch wrap keeps busy high while the mark table is cleared.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_MAX) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		clear_ids(MODEL_GEN);
		clear_ids(MODEL_CHK);
		for (int i = 0; i < MAX_IDS; i++) begin
			free_ids[MODEL_GEN][i] = '0;
			free_ids[MODEL_CHK][i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: fresh ids, pushes, repeats, range errors, topmost release of a stacked id.
		idle_pct = 16;
		add_word(idafs_pkg::OP_RELEASE, 10'd0);
		add_word(idafs_pkg::OP_ALLOC, 10'h3FF);
		add_word(idafs_pkg::OP_ALLOC, 10'd0);
		add_word(idafs_pkg::OP_ALLOC, 10'h155);
		add_word(idafs_pkg::OP_RELEASE, 10'd1);
		add_word(idafs_pkg::OP_RELEASE, 10'd1);
		add_word(idafs_pkg::OP_RELEASE, 10'd2);
		add_word(idafs_pkg::OP_RELEASE, 10'd1);
		add_word(idafs_pkg::OP_ALLOC, 10'd0);
		add_word(idafs_pkg::OP_ALLOC, 10'd0);
		add_word(idafs_pkg::OP_RELEASE, 10'd5);
		add_word(idafs_pkg::OP_RELEASE, 10'h3FF);
		add_word(idafs_pkg::OP_ALLOC, 10'd0);
		add_word(idafs_pkg::OP_RELEASE, 10'd0);
		add_word(idafs_pkg::OP_RELEASE, 10'd0);
		add_word(OP_UNUSED, 10'h3FF);
		add_word(OP_UNUSED, 10'd0);
		add_word(idafs_pkg::OP_RELEASE_ALL, 10'h2AA);
		add_word(idafs_pkg::OP_RELEASE, 10'd0);
		add_word(idafs_pkg::OP_ALLOC, 10'd0);
		add_word(idafs_pkg::OP_ALLOC, 10'd0);
		add_word(idafs_pkg::OP_RELEASE, 10'd0);
		add_word(idafs_pkg::OP_RELEASE_ALL, 10'd0);
		random_burst(150);
		drain();

		// Leave free marks set, then wrap the mark epoch; none of them may survive.
		idle_pct = 45;
		for (int i = 0; i < 8; i++)
			add_word(idafs_pkg::OP_ALLOC, ID_W'($urandom));
		for (int i = 0; i < 7; i++)
			add_word(idafs_pkg::OP_RELEASE, ID_W'(i));
		for (int i = 0; i < 256; i++)
			add_word(idafs_pkg::OP_RELEASE_ALL, ID_W'($urandom));
		for (int i = 0; i < 8; i++)
			add_word(idafs_pkg::OP_ALLOC, ID_W'($urandom));
		for (int i = 0; i < 7; i++)
			add_word(idafs_pkg::OP_RELEASE, ID_W'(i));
		random_burst(100);
		drain();

		// Hand out a long run of fresh ids, then work around the high-water mark.
		idle_pct = 0;
		add_word(idafs_pkg::OP_RELEASE_ALL, 10'd0);
		for (int i = 0; i < 300; i++)
			add_word(idafs_pkg::OP_ALLOC, ID_W'($urandom));
		add_word(idafs_pkg::OP_RELEASE, 10'd299);
		add_word(idafs_pkg::OP_RELEASE, 10'd150);
		add_word(idafs_pkg::OP_RELEASE, 10'd149);
		add_word(idafs_pkg::OP_RELEASE, 10'd299);
		random_burst(40);
		drain();

		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
